// File: rtl/i2cbe_pkg.sv
package i2cbe_pkg;

   localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;
   localparam logic [7:0]  POLL_LIMIT_RESET  = 8'd200;
   localparam logic [3:0]  BYTE_BITS         = 4'd8;
   localparam logic [3:0]  CLEAR_PULSES      = 4'd9;
   localparam logic [7:0]  MSB_MASK          = 8'h80;

   localparam logic [1:0]  CSR_PHASE_TICKS   = 2'd0;
   localparam logic [1:0]  CSR_POLL_LIMIT    = 2'd1;

   localparam logic [2:0]  CMD_START   = 3'd0;
   localparam logic [2:0]  CMD_STOP    = 3'd1;
   localparam logic [2:0]  CMD_SEND    = 3'd2;
   localparam logic [2:0]  CMD_RD_ACK  = 3'd3;
   localparam logic [2:0]  CMD_RD_NACK = 3'd4;
   localparam logic [2:0]  CMD_CLEAR   = 3'd5;

   typedef enum logic [2:0] {
      OP_IDLE    = 3'd0,
      OP_START   = 3'd1,
      OP_STOP    = 3'd2,
      OP_SEND    = 3'd3,
      OP_RD_ACK  = 3'd4,
      OP_RD_NACK = 3'd5,
      OP_CLEAR   = 3'd6
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  phase_step;
      logic [3:0]  bit_count;
      logic [7:0]  shift_reg;
      logic [15:0] tick_count;
      logic [7:0]  poll_count;
      logic        scl_level;
      logic        sda_level;
      logic [7:0]  rx_hold;
      logic        ack_err_hold;
      logic        stuck_hold;
   } st_type;

   localparam st_type ST_RESET = '{
      op:           OP_IDLE,
      phase_step:   4'd0,
      bit_count:    4'd0,
      shift_reg:    8'd0,
      tick_count:   16'd0,
      poll_count:   8'd0,
      scl_level:    1'b1,
      sda_level:    1'b1,
      rx_hold:      8'd0,
      ack_err_hold: 1'b0,
      stuck_hold:   1'b0
   };

   typedef struct packed {
      logic        scl_out;
      logic        sda_out;
      logic        busy_res;
      logic        done_res;
      logic [7:0]  rx_byte;
      logic        ack_error;
      logic        sda_stuck;
   } res_type;

   typedef struct packed {
      logic [15:0] phase_ticks;
      logic [7:0]  ack_poll_limit;
   } cfg_type;

   typedef struct packed {
      logic scl;
      logic sda;
   } lines_type;

   // Line levels set on entry to a bus phase.
   function automatic lines_type enter_lines(op_type op, logic [3:0] s,
                                             logic [7:0] shift, lines_type cur);
      lines_type l;
      l = cur;
      case (op)
         OP_START: begin
            if (s == 4'd0) begin
               l.scl = 1'b1;
               l.sda = 1'b1;
            end else if (s == 4'd1) begin
               l.sda = 1'b0;
            end else begin
               l.scl = 1'b0;
            end
         end
         OP_STOP: begin
            if (s == 4'd0) begin
               l.scl = 1'b0;
               l.sda = 1'b0;
            end else if (s == 4'd1) begin
               l.scl = 1'b1;
            end else begin
               l.sda = 1'b1;
            end
         end
         OP_SEND: begin
            if (s == 4'd0) begin
               l.scl = 1'b0;
               l.sda = (shift & MSB_MASK) != 8'd0;
            end else if (s == 4'd1 || s == 4'd3) begin
               l.scl = 1'b1;
            end else if (s == 4'd2) begin
               l.scl = 1'b0;
               l.sda = 1'b1;
            end else if (s == 4'd5) begin
               l.scl = 1'b0;
            end
         end
         OP_RD_ACK, OP_RD_NACK: begin
            if (s == 4'd0) begin
               l.scl = 1'b0;
               l.sda = 1'b1;
            end else if (s == 4'd1 || s == 4'd3) begin
               l.scl = 1'b1;
            end else if (s == 4'd2) begin
               l.scl = 1'b0;
               l.sda = (op == OP_RD_ACK) ? 1'b0 : 1'b1;
            end else begin
               l.scl = 1'b0;
            end
         end
         OP_CLEAR: begin
            if (s == 4'd0 || s == 4'd5) begin
               l.sda = 1'b1;
            end else if (s == 4'd1 || s == 4'd4) begin
               l.scl = 1'b1;
            end else if (s == 4'd2) begin
               l.scl = 1'b0;
            end else begin
               l.sda = 1'b0;
            end
         end
         default: begin
            l = cur;
         end
      endcase
      return l;
   endfunction

endpackage

// File: rtl/i2cbe_req_if.sv
interface i2cbe_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [2:0] opcode;
   logic [7:0] tx_byte;
   logic       sda_in;

   modport source (output valid, output cmd_valid, output opcode, output tx_byte,
                   output sda_in, input ready);
   modport sink (input valid, input cmd_valid, input opcode, input tx_byte,
                 input sda_in, output ready);
endinterface

// File: rtl/i2cbe_rsp_if.sv
interface i2cbe_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_error;
   logic       sda_stuck;

   modport source (output valid, output scl_out, output sda_out, output busy_res,
                   output done_res, output rx_byte, output ack_error,
                   output sda_stuck, input ready);
   modport sink (input valid, input scl_out, input sda_out, input busy_res,
                 input done_res, input rx_byte, input ack_error, input sda_stuck,
                 output ready);
endinterface

// File: rtl/i2cbe_step.sv
module i2cbe_step (
   input  i2cbe_pkg::st_type  cur,
   input  i2cbe_pkg::cfg_type cfg,
   input  logic               cmd_valid,
   input  logic [2:0]         opcode,
   input  logic [7:0]         tx_byte,
   input  logic               sda_in,
   output i2cbe_pkg::st_type  nxt,
   output i2cbe_pkg::res_type res
);

   logic                 done;
   logic                 do_enter;
   logic [3:0]           enter_step;
   logic [15:0]          period;
   logic [15:0]          tick_inc;
   logic [3:0]           bit_inc;
   i2cbe_pkg::lines_type lines_cur;
   i2cbe_pkg::lines_type lines_new;

   assign period   = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
   assign tick_inc = cur.tick_count + 16'd1;
   assign bit_inc  = cur.bit_count + 4'd1;

   always_comb begin
      nxt        = cur;
      done       = 1'b0;
      do_enter   = 1'b0;
      enter_step = 4'd0;
      if (cur.op == i2cbe_pkg::OP_IDLE) begin
         if (cmd_valid && opcode <= i2cbe_pkg::CMD_CLEAR) begin
            nxt.op         = i2cbe_pkg::op_type'(opcode + 3'd1);
            nxt.bit_count  = 4'd0;
            nxt.poll_count = 8'd0;
            nxt.shift_reg  = (opcode == i2cbe_pkg::CMD_SEND) ? tx_byte : 8'd0;
            do_enter       = 1'b1;
         end
      end else if (cur.op == i2cbe_pkg::OP_SEND && cur.phase_step == 4'd4) begin
         if (!sda_in) begin
            nxt.ack_err_hold = 1'b0;
            do_enter         = 1'b1;
            enter_step       = 4'd5;
         end else if (cur.poll_count >= cfg.ack_poll_limit) begin
            nxt.ack_err_hold = 1'b1;
            do_enter         = 1'b1;
            enter_step       = 4'd5;
         end else begin
            nxt.poll_count = cur.poll_count + 8'd1;
         end
      end else begin
         nxt.tick_count = tick_inc;
         if (tick_inc >= period) begin
            case (cur.op)
               i2cbe_pkg::OP_START, i2cbe_pkg::OP_STOP: begin
                  if (cur.phase_step < 4'd2) begin
                     do_enter   = 1'b1;
                     enter_step = cur.phase_step + 4'd1;
                  end else begin
                     done = 1'b1;
                  end
               end
               i2cbe_pkg::OP_SEND: begin
                  if (cur.phase_step == 4'd0 || cur.phase_step == 4'd2 ||
                      cur.phase_step == 4'd3) begin
                     do_enter   = 1'b1;
                     enter_step = cur.phase_step + 4'd1;
                  end else if (cur.phase_step == 4'd1) begin
                     nxt.shift_reg = {cur.shift_reg[6:0], 1'b0};
                     nxt.bit_count = bit_inc;
                     do_enter      = 1'b1;
                     enter_step    = (bit_inc < i2cbe_pkg::BYTE_BITS) ? 4'd0 : 4'd2;
                  end else begin
                     done = 1'b1;
                  end
               end
               i2cbe_pkg::OP_RD_ACK, i2cbe_pkg::OP_RD_NACK: begin
                  if (cur.phase_step == 4'd0 || cur.phase_step == 4'd2 ||
                      cur.phase_step == 4'd3) begin
                     do_enter   = 1'b1;
                     enter_step = cur.phase_step + 4'd1;
                  end else if (cur.phase_step == 4'd1) begin
                     nxt.shift_reg = {cur.shift_reg[6:0], sda_in};
                     nxt.bit_count = bit_inc;
                     do_enter      = 1'b1;
                     enter_step    = (bit_inc < i2cbe_pkg::BYTE_BITS) ? 4'd0 : 4'd2;
                  end else begin
                     nxt.sda_level = 1'b1;
                     nxt.rx_hold   = cur.shift_reg;
                     done          = 1'b1;
                  end
               end
               i2cbe_pkg::OP_CLEAR: begin
                  if (cur.phase_step == 4'd0 || cur.phase_step == 4'd1 ||
                      cur.phase_step == 4'd3 || cur.phase_step == 4'd4) begin
                     do_enter   = 1'b1;
                     enter_step = cur.phase_step + 4'd1;
                  end else if (cur.phase_step == 4'd2) begin
                     nxt.bit_count = bit_inc;
                     do_enter      = 1'b1;
                     enter_step    = (bit_inc < i2cbe_pkg::CLEAR_PULSES) ? 4'd1 : 4'd3;
                  end else begin
                     nxt.stuck_hold = !sda_in;
                     done           = 1'b1;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
      end
      if (done) begin
         nxt.op         = i2cbe_pkg::OP_IDLE;
         nxt.phase_step = 4'd0;
         nxt.bit_count  = 4'd0;
         nxt.tick_count = 16'd0;
      end
      lines_cur.scl = nxt.scl_level;
      lines_cur.sda = nxt.sda_level;
      lines_new = i2cbe_pkg::enter_lines(nxt.op, enter_step, nxt.shift_reg, lines_cur);
      if (do_enter) begin
         nxt.phase_step = enter_step;
         nxt.tick_count = 16'd0;
         nxt.scl_level  = lines_new.scl;
         nxt.sda_level  = lines_new.sda;
      end
   end

   always_comb begin
      res.scl_out   = nxt.scl_level;
      res.sda_out   = nxt.sda_level;
      res.busy_res  = nxt.op != i2cbe_pkg::OP_IDLE;
      res.done_res  = done;
      res.rx_byte   = nxt.rx_hold;
      res.ack_error = nxt.ack_err_hold;
      res.sda_stuck = nxt.stuck_hold;
   end

endmodule

// File: rtl/i2c_master_bit_engine_unit.sv
// I2C master bit engine. Every request beat is one bus tick carrying an optional command
// (start, stop, send byte, read with ack, read with nack, bus clear) and the sampled SDA
// level; every request beat yields exactly one response beat with the SCL and SDA drive
// levels, busy and done flags and the held results of the last read, send and bus clear.
// Commands presented while busy or with an undefined opcode are ignored. Each bus phase
// lasts phase_ticks ticks (zero acts as one), and the ack wait polls SDA up to
// ack_poll_limit + 1 times. The whole state update fits between the state register and the
// response register, so the response beat for a tick is offered on the cycle after it is
// taken. A new tick is taken in every cycle in which the response register is empty or
// its beat is taken in that same cycle; a response beat left waiting holds off the next
// tick. Configuration writes are meant to happen while no tick is in flight.
module i2c_master_bit_engine_unit (
   input  logic              clock,
   input  logic              reset,
   i2cbe_req_if.sink         req_chan,
   i2cbe_rsp_if.source       rsp_chan,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   i2cbe_pkg::st_type  st_ff;
   i2cbe_pkg::st_type  st_in;
   i2cbe_pkg::cfg_type cfg_ff;
   i2cbe_pkg::res_type res_ff;
   i2cbe_pkg::res_type res_in;
   logic               rsp_valid_ff;
   logic               accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   i2cbe_step u_step (
      .cur       (st_ff),
      .cfg       (cfg_ff),
      .cmd_valid (req_chan.cmd_valid),
      .opcode    (req_chan.opcode),
      .tx_byte   (req_chan.tx_byte),
      .sda_in    (req_chan.sda_in),
      .nxt       (st_in),
      .res       (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff              <= i2cbe_pkg::ST_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (accept) begin
            st_ff        <= st_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks    <= i2cbe_pkg::PHASE_TICKS_RESET;
         cfg_ff.ack_poll_limit <= i2cbe_pkg::POLL_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            i2cbe_pkg::CSR_PHASE_TICKS: cfg_ff.phase_ticks    <= csr_wdata;
            i2cbe_pkg::CSR_POLL_LIMIT:  cfg_ff.ack_poll_limit <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.scl_out   = res_ff.scl_out;
   assign rsp_chan.sda_out   = res_ff.sda_out;
   assign rsp_chan.busy_res  = res_ff.busy_res;
   assign rsp_chan.done_res  = res_ff.done_res;
   assign rsp_chan.rx_byte   = res_ff.rx_byte;
   assign rsp_chan.ack_error = res_ff.ack_error;
   assign rsp_chan.sda_stuck = res_ff.sda_stuck;

endmodule
